@@ rtl/core/lpht_pkg.sv @@
// Package for the linear-probe hash table core: request/result types,
// operation and status codes, state encoding. No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [15:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_value;
    logic [9:0]  slot;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_FIN, S_MOD, S_PROBE_RD, S_PROBE_CHK, S_CLEAR, S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request
    logic hash_step;  // one key byte into hash
    logic fin_step;   // one final-mix step
    logic mod_init;
    logic mod_step;
    logic adv;        // pos <- next
    logic wr;         // write insert slot
    logic clr_step;   // clear one slot
    logic clr_init;
    logic set_ok;
    logic set_miss;
    logic set_full;
    logic set_hit;
    logic set_slot;
    logic strobe;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic hash_last;
    logic fin_last;
    logic mod_last;
    logic used;
    logic match;
    logic probe_last;
    logic clr_last;
  } sts_t;

endpackage

@@ rtl/core/lpht_ram.sv @@
// Generic single-port RAM, registered read. No dependencies.
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

@@ rtl/core/lpht_ctrl.sv @@
// Controller FSM of the hash table core. Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t cmd_o
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      // sweep every slot empty after reset, no result
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        unique case (func_e'(sts_i.func))
          FUNC_CLEAR: begin
            cmd_o.clr_init = 1'b1;
            state_d = S_CLEAR;
          end
          FUNC_NOP: begin
            cmd_o.set_ok = 1'b1;
            state_d = S_DONE;
          end
          default: begin
            if (sts_i.hash_last) state_d = S_FIN;
            else cmd_o.hash_step = 1'b1;
          end
        endcase
      end
      S_FIN: begin
        cmd_o.fin_step = 1'b1;
        if (sts_i.fin_last) begin
          cmd_o.mod_init = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_d = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts_i.func == FUNC_INSERT) begin
          if (!sts_i.used) begin
            cmd_o.wr = 1'b1;
            cmd_o.set_ok = 1'b1;
            cmd_o.set_slot = 1'b1;
            state_d = S_DONE;
          end else if (sts_i.probe_last) begin
            cmd_o.set_full = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.adv = 1'b1;
            state_d = S_PROBE_RD;
          end
        end else begin
          if (sts_i.match) begin
            cmd_o.set_hit = 1'b1;
            cmd_o.set_slot = 1'b1;
            state_d = S_DONE;
          end else if (sts_i.probe_last) begin
            cmd_o.set_miss = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.adv = 1'b1;
            state_d = S_PROBE_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.set_ok = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.strobe = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/lpht_dp.sv @@
// Datapath: hash unit, restoring modulo, probe pointer, slot memories.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps
module lpht_dp #(
  parameter int TableDepth = 1024,
  parameter int KeyBytes   = 8,
  parameter int ValueBits  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpht_pkg::req_t  req_i,
  input  logic [10:0]     size_i,
  input  lpht_pkg::cmd_t  cmd_i,
  output lpht_pkg::sts_t  sts_o,
  output lpht_pkg::rsp_t  rsp_o
);
  import lpht_pkg::*;

  localparam int AW = $clog2(TableDepth);
  localparam int SW = AW + 1;
  localparam int LW = $clog2(KeyBytes + 1);
  localparam int KW = 8 * KeyBytes;
  localparam int EW = 1 + LW + KW;  // used + len + key

  logic [1:0]    func_q;
  logic [KW-1:0] key_q, hkey_q;
  logic [LW-1:0] len_q, idx_q;
  logic [ValueBits-1:0] val_q;
  logic [31:0]   h_q, h_d;
  logic [1:0]    fin_q;
  logic [31:0]   rem_q;
  logic [5:0]    mbit_q;
  logic [SW-1:0] size_q;
  logic [AW-1:0] pos_q, clr_q;
  logic [SW-1:0] cnt_q;
  rsp_t          rsp_q;

  // effective size
  logic [SW-1:0] eff_size;
  always_comb begin
    if (size_i == '0) eff_size = SW'(1);
    else if (32'(size_i) > TableDepth) eff_size = SW'(TableDepth);
    else eff_size = SW'(size_i);
  end

  // saturate and mask key
  logic [LW-1:0] len_sat;
  logic [KW-1:0] key_m;
  always_comb begin
    if (32'(req_i.key_length) > KeyBytes) len_sat = LW'(KeyBytes);
    else len_sat = LW'(req_i.key_length);
    for (int b = 0; b < KeyBytes; b++)
      key_m[8*b +: 8] = (b < int'(len_sat)) ? req_i.key_bytes[8*b +: 8] : 8'h00;
  end

  // one-at-a-time step over current byte
  logic [7:0]  cur_byte;
  logic [31:0] ha, hb, hc;
  assign cur_byte = hkey_q[7:0];
  always_comb begin
    ha = h_q + {24'd0, cur_byte};
    hb = ha + (ha << 10);
    hc = hb ^ (hb >> 6);
    h_d = hc;
    if (cmd_i.fin_step) begin
      unique case (fin_q)
        2'd0: h_d = h_q + (h_q << 3);
        2'd1: h_d = h_q ^ (h_q >> 11);
        default: h_d = h_q + (h_q << 15);
      endcase
    end
  end

  // restoring modulo, one quotient bit per cycle
  logic [63:0] shifted;
  assign shifted = 64'(size_q) << mbit_q;

  // memory
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [ValueBits-1:0] vrd;
  assign we    = cmd_i.wr | cmd_i.clr_step;
  assign addr  = cmd_i.clr_step ? clr_q : pos_q;
  assign wdata = cmd_i.clr_step ? '0 : {1'b1, len_q, key_q};

  lpht_ram #(.Width(EW), .Depth(TableDepth)) u_ent (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
  lpht_ram #(.Width(ValueBits), .Depth(TableDepth)) u_val (
    .clk_i, .we_i(cmd_i.wr), .addr_i(pos_q), .wdata_i(val_q), .rdata_o(vrd)
  );

  logic [AW-1:0] pos_nx;
  assign pos_nx = ({1'b0, pos_q} + SW'(1) == size_q) ? '0 : pos_q + AW'(1);

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.hash_last  = (idx_q == len_q);
    sts_o.fin_last   = (fin_q == 2'd2);
    sts_o.mod_last   = (mbit_q == 6'd0);
    sts_o.used       = rdata[EW-1];
    sts_o.match      = rdata[EW-1] && (rdata[EW-2 -: LW] == len_q) &&
                       (rdata[KW-1:0] == key_q);
    sts_o.probe_last = (cnt_q == size_q);
    sts_o.clr_last   = (clr_q == AW'(TableDepth - 1));
  end

  assign rsp_o = rsp_q;

  // clear pointer starts at zero for the sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_init) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= req_i.func;
      key_q  <= key_m;
      hkey_q <= key_m;
      len_q  <= len_sat;
      idx_q  <= '0;
      val_q  <= ValueBits'(req_i.entry_value);
      h_q    <= '0;
      fin_q  <= '0;
      size_q <= eff_size;
      rsp_q  <= '0;
    end
    if (cmd_i.hash_step) begin
      h_q    <= h_d;
      idx_q  <= idx_q + LW'(1);
      hkey_q <= hkey_q >> 8;
    end
    if (cmd_i.fin_step) begin
      h_q   <= h_d;
      fin_q <= fin_q + 2'd1;
    end
    if (cmd_i.mod_init) begin
      rem_q  <= h_d;
      mbit_q <= 6'd31;
    end
    if (cmd_i.mod_step) begin
      if (shifted[63:32] == '0 && rem_q >= shifted[31:0]) rem_q <= rem_q - shifted[31:0];
      mbit_q <= mbit_q - 6'd1;
      if (mbit_q == 6'd0) begin
        pos_q <= (rem_q >= 32'(size_q)) ? AW'(rem_q - 32'(size_q)) : AW'(rem_q);
        cnt_q <= SW'(1);
      end
    end
    if (cmd_i.adv) begin
      pos_q <= pos_nx;
      cnt_q <= cnt_q + SW'(1);
    end
    if (cmd_i.set_ok)   rsp_q.status <= ST_OK;
    if (cmd_i.set_miss) rsp_q.status <= ST_MISS;
    if (cmd_i.set_full) rsp_q.status <= ST_FULL;
    if (cmd_i.set_hit) begin
      rsp_q.status <= ST_OK;
      rsp_q.found_value <= 16'(vrd);
    end
    if (cmd_i.set_slot) rsp_q.slot <= 10'(pos_q);
  end
endmodule

@@ rtl/core/linear_probe_hash_table_core.sv @@
// Linear-probing hash table core, top level. An operation is requested with start while busy
// is low; done_o is high for one cycle with the result on rsp_o, which holds it until the
// next request is accepted, and the receiver cannot stall. After reset busy stays high while
// every slot is swept empty. A clear sweeps every slot of the table (one slot written per
// cycle); a no-op goes straight to the result; insert and lookup hash the saturated key bytes,
// apply the final mix, reduce the hash by a bit-serial modulo over 32 quotient bits, then
// spend one RAM read and one check per probed slot before the result. The core returns to
// idle before the next request. The table size register is written only while idle with no
// request offered. Depends on lpht_pkg, lpht_ctrl, lpht_dp.
`timescale 1ns / 1ps
module linear_probe_hash_table_core #(
  parameter int TableDepth = 1024,
  parameter int KeyBytes   = 8,
  parameter int ValueBits  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lpht_pkg::req_t req_i,
  output logic           done_o,
  output lpht_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [10:0]    cfg_data_i
);
  import lpht_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [10:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 11'd1024;
    else if (cfg_valid_i && cfg_ready_o) size_q <= cfg_data_i;
  end

  assign cfg_ready_o = !busy && !start;
  assign done_o      = cmd.strobe;

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  lpht_dp #(
    .TableDepth(TableDepth), .KeyBytes(KeyBytes), .ValueBits(ValueBits)
  ) u_dp (
    .clk_i, .rst_ni, .req_i, .size_i(size_q), .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted without going busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> (!busy && !start)) else $error("size write while active");
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for linear_probe_hash_table_core: directed and random
// clear/insert/lookup requests checked against a behavioral table model.
// Depends on lpht_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import lpht_pkg::*;

  localparam int Depth = 1024;
  localparam longint CycleLimit = 6000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  linear_probe_hash_table_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // table model state
  logic        tbl_used [Depth];
  logic [63:0] tbl_key  [Depth];
  logic [3:0]  tbl_len  [Depth];
  logic [15:0] tbl_val  [Depth];
  logic [10:0] tbl_size;

  rsp_t   pending_rsp[$];
  int     mismatches = 0;
  int     sent_reqs = 0;
  int     hits = 0;
  int     fulls = 0;
  longint cycles = 0;
  int     idle_pct = 0;

  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  function automatic logic [31:0] oat_hash(logic [63:0] key, int len);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < len; i++) begin
      h = h + {24'd0, key[i*8 +: 8]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // applies one request to the table model and returns the expected response
  function automatic rsp_t table_apply(req_t r);
    rsp_t        res;
    int          sz;
    int          len;
    int          pos;
    logic [63:0] key;
    res = '0;
    sz  = (tbl_size == 0) ? 1 : (tbl_size > Depth) ? Depth : int'(tbl_size);
    len = (r.key_length > 8) ? 8 : int'(r.key_length);
    key = (len >= 8) ? r.key_bytes : r.key_bytes & ((64'd1 << (len * 8)) - 64'd1);
    res.status = ST_OK;
    case (func_e'(r.func))
      FUNC_CLEAR: begin
        for (int i = 0; i < Depth; i++) tbl_used[i] = 1'b0;
      end
      FUNC_NOP: ;
      FUNC_INSERT: begin
        pos = int'(oat_hash(key, len) % sz);
        res.status = ST_FULL;
        for (int n = 0; n < sz; n++) begin
          if (!tbl_used[pos]) begin
            tbl_used[pos] = 1'b1;
            tbl_key[pos]  = key;
            tbl_len[pos]  = 4'(len);
            tbl_val[pos]  = r.entry_value;
            res.status    = ST_OK;
            res.slot      = 10'(pos);
            break;
          end
          pos = (pos + 1 == sz) ? 0 : pos + 1;
        end
      end
      default: begin
        pos = int'(oat_hash(key, len) % sz);
        res.status = ST_MISS;
        for (int n = 0; n < sz; n++) begin
          if (tbl_used[pos] && tbl_len[pos] == 4'(len) && tbl_key[pos] == key) begin
            res.status      = ST_OK;
            res.found_value = tbl_val[pos];
            res.slot        = 10'(pos);
            break;
          end
          pos = (pos + 1 == sz) ? 0 : pos + 1;
        end
      end
    endcase
    return res;
  endfunction

  // response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.found_value !== want.found_value ||
            rsp_o.slot !== want.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected status %0d value %h slot %0d, got %0d %h %0d",
                     want.status, want.found_value, want.slot,
                     rsp_o.status, rsp_o.found_value, rsp_o.slot);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("linear_probe_hash_table_core: mismatch");
      $finish;
    end
  end

  // start stays high into the next request when no idle gap follows
  task automatic send_req(func_e f, logic [63:0] key, logic [3:0] len, logic [15:0] val);
    req_t r;
    rsp_t want;
    r.func = f;
    r.key_bytes = key;
    r.key_length = len;
    r.entry_value = val;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    want = table_apply(r);
    if (f == FUNC_LOOKUP && want.status == ST_OK) hits++;
    if (want.status == ST_FULL) fulls++;
    pending_rsp.push_back(want);
    sent_reqs++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_size(logic [10:0] sz);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk_i); while (!cfg_ready);
    tbl_size = sz;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_req(FUNC_CLEAR, '0, 4'd0, '0);
    send_req(FUNC_INSERT, 64'hdead_beef_0000_0000, 4'd0, 16'h0001);  // empty key
    send_req(FUNC_INSERT, '1, 4'd8, 16'hffff);
    send_req(FUNC_INSERT, 64'h0000_0000_0000_0000, 4'd3, 16'h1234);   // zero bytes
    send_req(FUNC_INSERT, 64'hffff_ff00_6f6c_6c65, 4'd5, 16'h0042);   // high bytes ignored
    send_req(FUNC_INSERT, 64'h0123_4567_89ab_cdef, 4'd15, 16'h5555);  // length saturates
    send_req(FUNC_LOOKUP, '0, 4'd0, '0);
    send_req(FUNC_LOOKUP, '1, 4'd8, '0);
    send_req(FUNC_LOOKUP, '0, 4'd3, '0);
    send_req(FUNC_LOOKUP, '0, 4'd2, '0);                               // miss
    send_req(FUNC_LOOKUP, 64'h0000_0012_6f6c_6c65, 4'd5, '0);
    send_req(FUNC_LOOKUP, 64'h0123_4567_89ab_cdef, 4'd8, '0);
    send_req(FUNC_NOP, '1, 4'd8, '1);
    send_req(FUNC_LOOKUP, '1, 4'd7, '0);
    // shrink: old slots keep contents, unreachable until grown again
    write_size(11'd0);
    send_req(FUNC_LOOKUP, '1, 4'd8, '0);
    send_req(FUNC_INSERT, 64'h41, 4'd1, 16'h00aa);
    send_req(FUNC_INSERT, 64'h42, 4'd1, 16'h00bb);                     // full
    send_req(FUNC_LOOKUP, 64'h41, 4'd1, '0);
    write_size(11'd2047);
    send_req(FUNC_LOOKUP, '1, 4'd8, '0);
    send_req(FUNC_LOOKUP, 64'h0123_4567_89ab_cdef, 4'd8, '0);
    send_req(FUNC_CLEAR, '1, 4'd15, '1);
    send_req(FUNC_LOOKUP, '1, 4'd8, '0);
  endtask

  task automatic test_random(logic [10:0] sz, int count, int pct);
    func_e       f;
    int          pick;
    int          k;
    logic [63:0] key;
    logic [3:0]  len;
    write_size(sz);
    idle_pct = pct;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = 4'($urandom_range(15));
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      f = (pick < 2) ? FUNC_CLEAR : (pick < 5) ? FUNC_NOP :
          (pick < 50) ? FUNC_INSERT : FUNC_LOOKUP;
      k = $urandom_range(15);
      if ($urandom_range(9) < 7) begin
        // pooled key, random bits above the key length
        len = len_pool[k];
        key = (len >= 8) ? key_pool[k] :
              (key_pool[k] & ((64'd1 << (len * 8)) - 1)) |
              ({$urandom, $urandom} & ~((64'd1 << (len * 8)) - 1));
      end else begin
        len = 4'($urandom_range(15));
        key = {$urandom, $urandom};
      end
      send_req(f, key, len, 16'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_len[i]  = '0;
      tbl_val[i]  = '0;
    end
    tbl_size = 11'd1024;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(11'd7, 150, 0);
    test_random(11'd1, 60, 48);
    test_random(11'd16, 180, 14);
    test_random(11'd64, 200, 0);
    test_random(11'd3, 100, 48);
    test_random(11'd33, 150, 14);
    test_random(11'd1024, 80, 48);
    test_random(11'd2047, 40, 0);
    test_random(11'd5, 60, 14);
    drain();

    $display("%0d requests sent over table sizes 0..2047, %0d lookup hits, %0d full inserts",
             sent_reqs, hits, fulls);
    if (mismatches == 0) begin
      $display("linear_probe_hash_table_core: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("linear_probe_hash_table_core: mismatch");
    end
    $finish;
  end

endmodule
